// ----- hdl/sitda_pkg.sv -----
// Shared types and constants for the signed integer to decimal ASCII converter.
package sitda_pkg;

  // Decimal digits held for a magnitude of up to 32 bits (2^31 has ten digits)
  localparam int DIGIT_SLOTS = 10;
  localparam int DIG_IDX_W   = $clog2(DIGIT_SLOTS);
  localparam int BCD_W       = 4 * DIGIT_SLOTS;
  // Character position counter: covers a padded length of up to 31
  localparam int LEN_W       = 6;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture value and digit count
    logic shift;  // one shift-add-3 conversion step
    logic prep;   // set character position, send sign if negative
    logic emit;   // send one digit character
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic conv_last;  // final conversion step this cycle
    logic pos_zero;   // current character is the last one
  } sts_t;

endpackage

// ----- hdl/sitda_ctrl.sv -----
// Controller state machine for the signed integer to decimal ASCII converter.
module sitda_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  sitda_pkg::sts_t  sts,
  output sitda_pkg::cmd_t  cmd
);
  import sitda_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_PREP  = 4'b0100,
    ST_DIGIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_last) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        cmd.emit = 1'b1;
        if (sts.pos_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // A transfer in always starts a conversion
  a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_CONV))
    else $error("accepted item did not start conversion");

  // Conversion runs until the datapath flags the final step
  a_conv_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && !sts.conv_last) |=> (state_r == ST_CONV))
    else $error("conversion left early");

  // The last digit returns the block to idle
  a_digit_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT && sts.pos_zero) |=> (state_r == ST_IDLE))
    else $error("no return to idle after last digit");

endmodule

// ----- hdl/sitda_dp.sv -----
// Datapath: magnitude capture, shift-add-3 conversion and character output.
module sitda_dp #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_PAD    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      in_value,
  input  logic [4:0]       in_min_digits,
  input  sitda_pkg::cmd_t  cmd,
  output sitda_pkg::sts_t  sts,
  output logic             out_strobe,
  output logic [6:0]       out_character,
  output logic             out_is_last
);
  import sitda_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam logic [6:0] MAX_PAD_W = 7'(MAX_PAD);

  logic [VALUE_BITS-1:0]             bin_r;
  logic [DIGIT_SLOTS-1:0][3:0]       bcd_r;
  logic [DIGIT_SLOTS-1:0][3:0]       bcd_adj;
  logic [DIGIT_SLOTS-1:0][3:0]       bcd_shift;
  logic                              neg_r;
  logic [4:0]                        pad_r;
  logic [4:0]                        pad_sat;
  logic [CNT_W-1:0]                  bcnt_r;
  logic [LEN_W-1:0]                  pos_r;
  logic [LEN_W-1:0]                  len;
  logic [DIG_IDX_W:0]                ndig;
  logic [VALUE_BITS-1:0]             raw;
  logic [VALUE_BITS-1:0]             mag;
  logic [3:0]                        cur_digit;
  logic                              out_strobe_r;
  logic [6:0]                        out_character_r;
  logic                              out_is_last_r;

  // Magnitude of the input; the most negative value maps onto itself
  assign raw = in_value[VALUE_BITS-1:0];
  assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  // Saturate the digit count at MAX_PAD
  assign pad_sat = ({2'b00, in_min_digits} > MAX_PAD_W) ? MAX_PAD_W[4:0] : in_min_digits;

  // Add 3 to every digit of five or more, then shift in the next binary bit
  always_comb begin
    for (int d = 0; d < DIGIT_SLOTS; d++) begin
      bcd_adj[d] = (bcd_r[d] >= 4'd5) ? (bcd_r[d] + 4'd3) : bcd_r[d];
    end
  end
  assign bcd_shift = BCD_W'({bcd_adj, bin_r[VALUE_BITS-1]});

  // Significant digit count: one above the highest nonzero digit
  always_comb begin
    ndig = '0;
    for (int d = 0; d < DIGIT_SLOTS; d++) begin
      if (bcd_r[d] != 4'd0) begin
        ndig = (DIG_IDX_W + 1)'(d + 1);
      end
    end
  end

  // Output length: max of significant digits, padding and one
  always_comb begin
    len = LEN_W'(ndig);
    if (LEN_W'(pad_r) > len) begin
      len = LEN_W'(pad_r);
    end
    if (len == '0) begin
      len = LEN_W'(1);
    end
  end

  // Digit at the current position; positions above the stored digits are zero
  assign cur_digit = (pos_r < LEN_W'(DIGIT_SLOTS)) ? bcd_r[pos_r[DIG_IDX_W-1:0]] : 4'd0;

  // Conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r  <= mag;
      bcd_r  <= '0;
      neg_r  <= raw[VALUE_BITS-1];
      pad_r  <= pad_sat;
      bcnt_r <= CNT_W'(VALUE_BITS - 1);
    end else if (cmd.shift) begin
      bin_r  <= bin_r << 1;
      bcd_r  <= bcd_shift;
      bcnt_r <= bcnt_r - 1'b1;
    end
  end

  // Character position: set from the length, count down per digit
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      pos_r <= len - 1'b1;
    end else if (cmd.emit) begin
      pos_r <= pos_r - 1'b1;
    end
  end

  // Result register: one transfer per strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cmd.prep & neg_r) | cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      out_character_r <= CHAR_MINUS;
      out_is_last_r   <= 1'b0;
    end else if (cmd.emit) begin
      out_character_r <= CHAR_ZERO + {3'b000, cur_digit};
      out_is_last_r   <= (pos_r == '0);
    end
  end

  assign sts.conv_last = (bcnt_r == '0);
  assign sts.pos_zero  = (pos_r == '0);

  assign out_strobe    = out_strobe_r;
  assign out_character = out_character_r;
  assign out_is_last   = out_is_last_r;

endmodule

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// After the start transfer, the shift-add-3 conversion takes in one bit of VALUE_BITS
// per cycle; then '-' goes out when the value is negative, followed by the digits.
// Characters go out one per cycle: optional '-' and max(digits, min(min_digits, MAX_PAD), 1) digits.
// A new start is accepted only once the block is idle again, as the final character goes out.
// Reset (rst_n low, synchronous) returns the controller to idle and drops the strobe.
// The receiver cannot stall: each result stands on the outputs for exactly one cycle.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_PAD    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value,
  input  logic [4:0]  in_min_digits,
  output logic        out_strobe,
  output logic [6:0]  out_character,
  output logic        out_is_last
);
  import sitda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the conversion and the character output
  sitda_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Convert and send characters
  sitda_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_PAD    (MAX_PAD)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .in_min_digits (in_min_digits),
    .cmd           (cmd),
    .sts           (sts),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_is_last   (out_is_last)
  );

  // Going idle coincides with the transfer of the final character
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_strobe && out_is_last))
    else $error("block went idle without a final character");

endmodule
